FILE: hdl/mlt_pkg.sv
// Package: shared constants, types and command codes of the MAC learning table.
package mlt_pkg;
  localparam int Buckets   = 16;
  localparam int Ways      = 4;
  localparam int StampBits = 32;
  localparam int Entries   = Buckets * Ways;
  localparam int BktW      = $clog2(Buckets);
  localparam int WayW      = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int EntW      = $clog2(Entries);

  typedef enum logic [1:0] {
    CMD_LEARN = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_REFRESH = 3'd1,
    ST_MOVE    = 3'd2,
    ST_FULL    = 3'd3,
    ST_FLUSHED = 3'd4,
    ST_TICKED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_EMPTY   = 2'd0,
    KIND_STATIC  = 2'd1,
    KIND_DYNAMIC = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic load;
    logic rd_start;
    logic scan;
    logic fl_start;
    logic learn_finish;
    logic flush_step;
    logic tick;
  } ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic flush_last;
  } stat_t;

  function automatic logic [BktW-1:0] bucket_of(input logic [47:0] mac,
                                                input logic [11:0] vlan);
    logic [11:0] h;
    h = vlan;
    for (int i = 0; i < 6; i++) begin
      h = h ^ {4'd0, mac[8*i +: 8]};
    end
    return h[BktW-1:0];
  endfunction
endpackage

FILE: hdl/mlt_if.sv
// Interfaces: request and result channels of the MAC learning table.
interface mlt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [47:0] mac_addr;
  logic [11:0] vlan_id;
  logic [4:0]  port_num;
  logic        is_static;
  modport source (output valid, cmd, mac_addr, vlan_id, port_num, is_static, input ready);
  modport sink (input valid, cmd, mac_addr, vlan_id, port_num, is_static, output ready);
endinterface

interface mlt_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] bucket_index;
  logic [1:0] way_index;
  logic [4:0] old_port;
  logic [6:0] removed_count;
  logic [2:0] aged_count;
  modport source (output valid, status, bucket_index, way_index, old_port, removed_count,
                  aged_count, input ready);
  modport sink (input valid, status, bucket_index, way_index, old_port, removed_count,
                aged_count, output ready);
endinterface

interface mlt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hdl/mlt_ctrl.sv
// Controller: sequences learn scans, flush sweeps and ticks.
module mlt_ctrl
  import mlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_t      ctrl,
  input  stat_t      stat
);
  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          case (cmd_t'(in_cmd))
            CMD_LEARN: begin
              ctrl.rd_start = 1'b1;
              state_nxt = S_SCAN;
            end
            CMD_FLUSH: begin
              ctrl.fl_start = 1'b1;
              state_nxt = S_FLUSH;
            end
            CMD_TICK: begin
              ctrl.tick = 1'b1;
              state_nxt = S_OUT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.scan_done) begin
          ctrl.learn_finish = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_FLUSH: begin
        ctrl.flush_step = 1'b1;
        if (stat.flush_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/mlt_dp.sv
// Datapath: entry memories, kind flags, timer and result registers.
module mlt_dp
  import mlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_t       ctrl,
  output stat_t       stat,
  input  logic [47:0] in_mac_addr,
  input  logic [11:0] in_vlan_id,
  input  logic [4:0]  in_port_num,
  input  logic        in_is_static,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic [2:0]  res_status,
  output logic [3:0]  res_bucket,
  output logic [1:0]  res_way,
  output logic [4:0]  res_old_port,
  output logic [6:0]  res_removed,
  output logic [2:0]  res_aged
);
  localparam int KeyW = 48 + 12;

  logic [KeyW-1:0]      key_mem [Entries];
  logic [StampBits-1:0] stamp_mem [Entries];
  logic [4:0]           port_mem [Entries];
  kind_t                kind_r [Entries];

  logic [47:0]          mac_r;
  logic [11:0]          vlan_r;
  logic [4:0]           port_r;
  logic                 static_r;
  logic [BktW-1:0]      bkt_r;
  logic [WayW:0]        way_r;
  logic [EntW-1:0]      fl_r;
  logic [StampBits-1:0] now_r;
  logic [15:0]          age_lim_r;
  logic                 free_ok_r;
  logic [WayW-1:0]      free_way_r;
  logic [2:0]           aged_r;
  logic [6:0]           removed_r;
  logic [2:0]           status_r;
  logic [WayW-1:0]      res_way_r;
  logic [4:0]           old_port_r;

  logic [KeyW-1:0]      rd_key_r;
  logic [StampBits-1:0] rd_stamp_r;
  logic [4:0]           rd_port_r;

  logic [WayW-1:0]      way_c;
  logic [EntW-1:0]      ent_c;
  logic [EntW-1:0]      rd_ent_c;
  logic [WayW:0]        rd_way_c;
  kind_t                kind_c;
  logic [StampBits-1:0] age_c;
  logic                 expire_c;
  logic                 match_c;
  logic                 last_way_c;
  logic                 wr_c;
  logic [EntW-1:0]      wr_ent_c;

  function automatic kind_t in_kind(input logic s);
    return s ? KIND_STATIC : KIND_DYNAMIC;
  endfunction

  assign way_c      = way_r[WayW-1:0];
  assign ent_c      = EntW'({bkt_r, way_c});
  assign kind_c     = kind_r[ent_c];
  assign age_c      = now_r - rd_stamp_r;
  assign expire_c   = (kind_c == KIND_DYNAMIC) && (age_c > StampBits'(age_lim_r));
  assign match_c    = (kind_c != KIND_EMPTY) && !expire_c &&
                      (rd_key_r == {mac_r, vlan_r});
  assign last_way_c = (way_r == (WayW+1)'(Ways - 1));
  assign stat.scan_done  = match_c || last_way_c;
  assign stat.flush_last = (fl_r == EntW'(Entries - 1));

  // read address: the bucket's way 0 at start, else the next way; flush walks from entry 0
  assign rd_way_c = ctrl.rd_start ? '0 : (way_r + 1'b1);
  assign rd_ent_c = ctrl.rd_start   ? EntW'({bucket_of(in_mac_addr, in_vlan_id), {WayW{1'b0}}})
                  : ctrl.fl_start   ? '0
                  : ctrl.flush_step ? fl_r + 1'b1
                  : EntW'({bkt_r, rd_way_c[WayW-1:0]});

  // write-back: refresh/move on hit, new entry into free way
  always_comb begin
    wr_c = 1'b0;
    wr_ent_c = ent_c;
    if (ctrl.scan && match_c) begin
      wr_c = 1'b1;
    end else if (ctrl.learn_finish && (free_ok_r || kind_c == KIND_EMPTY || expire_c)) begin
      wr_c = 1'b1;
      if (free_ok_r) wr_ent_c = EntW'({bkt_r, free_way_r});
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r   <= key_mem[rd_ent_c];
    rd_stamp_r <= stamp_mem[rd_ent_c];
    rd_port_r  <= port_mem[rd_ent_c];
    if (wr_c) begin
      stamp_mem[wr_ent_c] <= now_r;
      port_mem[wr_ent_c]  <= port_r;
      if (!match_c) key_mem[wr_ent_c] <= {mac_r, vlan_r};
    end
  end

  // flush sweep checks the port read in the previous cycle at its counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Entries; i++) kind_r[i] <= KIND_EMPTY;
      now_r     <= '0;
      age_lim_r <= 16'd5;
    end else begin
      if (cfg_we) age_lim_r <= cfg_data;
      if (ctrl.tick) now_r <= now_r + 1'b1;
      for (int i = 0; i < Entries; i++) begin
        if (wr_c && !match_c && wr_ent_c == EntW'(i)) begin
          kind_r[i] <= in_kind(static_r);
        end else if (ctrl.scan && expire_c && ent_c == EntW'(i)) begin
          kind_r[i] <= KIND_EMPTY;
        end else if (ctrl.flush_step && fl_r == EntW'(i) && kind_r[i] == KIND_DYNAMIC &&
                     rd_port_r == port_r) begin
          kind_r[i] <= KIND_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mac_r      <= in_mac_addr;
      vlan_r     <= in_vlan_id;
      port_r     <= in_port_num;
      static_r   <= in_is_static;
      bkt_r      <= bucket_of(in_mac_addr, in_vlan_id);
      way_r      <= '0;
      fl_r       <= '0;
      free_ok_r  <= 1'b0;
      aged_r     <= '0;
      removed_r  <= '0;
      old_port_r <= '0;
      res_way_r  <= '0;
      status_r   <= ST_TICKED;
    end
    if (ctrl.scan) begin
      way_r <= rd_way_c;
      if (expire_c) aged_r <= aged_r + 1'b1;
      if (!match_c && !free_ok_r && (kind_c == KIND_EMPTY || expire_c)) begin
        free_ok_r  <= 1'b1;
        free_way_r <= way_c;
      end
    end
    if (ctrl.learn_finish) begin
      if (match_c) begin
        res_way_r <= way_c;
        if (rd_port_r != port_r) begin
          status_r   <= ST_MOVE;
          old_port_r <= rd_port_r;
        end else begin
          status_r <= ST_REFRESH;
        end
      end else if (free_ok_r) begin
        status_r  <= ST_NEW;
        res_way_r <= free_way_r;
      end else if (kind_c == KIND_EMPTY || expire_c) begin
        status_r  <= ST_NEW;
        res_way_r <= way_c;
      end else begin
        status_r <= ST_FULL;
      end
    end
    if (ctrl.flush_step) begin
      status_r <= ST_FLUSHED;
      fl_r <= fl_r + 1'b1;
      if (kind_r[fl_r] == KIND_DYNAMIC && rd_port_r == port_r && removed_r != 7'd127)
        removed_r <= removed_r + 1'b1;
    end
  end

  assign res_status   = status_r;
  assign res_bucket   = (status_r <= ST_FULL) ? 4'(bkt_r) : 4'd0;
  assign res_way      = 2'(res_way_r);
  assign res_old_port = old_port_r;
  assign res_removed  = removed_r;
  assign res_aged     = aged_r;
endmodule

FILE: hdl/mac_learning_table.sv
// Top level: MAC learning table with controller and datapath.
// A four-way set-associative table of 64 source MAC/VLAN entries, bucket chosen by
// XOR of the VLAN and the six MAC bytes. One request gives one result. A learn
// reads its bucket one way a cycle through a registered memory port, stopping early
// on a match. A flush walks all 64 entries, one a cycle. Command code 3 is dropped
// with no result. Requests are taken one at a time; the result register holds until
// taken. The user must write age_limit through the cfg channel only while the table
// is idle; the block itself does not enforce it.
module mac_learning_table
  import mlt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  mlt_req_if.sink   in_ch,
  mlt_res_if.source out_ch,
  mlt_cfg_if.sink   cfg_ch
);
  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  mlt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_cmd (in_ch.cmd),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .ctrl, .stat
  );

  mlt_dp u_dp (
    .clk, .rst_n, .ctrl, .stat,
    .in_mac_addr (in_ch.mac_addr), .in_vlan_id (in_ch.vlan_id),
    .in_port_num (in_ch.port_num), .in_is_static (in_ch.is_static),
    .cfg_we (cfg_ch.valid), .cfg_data (cfg_ch.data),
    .res_status (out_ch.status), .res_bucket (out_ch.bucket_index),
    .res_way (out_ch.way_index), .res_old_port (out_ch.old_port),
    .res_removed (out_ch.removed_count), .res_aged (out_ch.aged_count)
  );
endmodule
